### rtl/indexed_list_engine_defines.svh
// Assertion macros for the indexed list engine.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define ILE_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define ILE_ASSERT_NEXT(lbl, clock, reset, pre, post, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define ILE_ASSERT(lbl, clock, reset, prop, msg)
`define ILE_ASSERT_NEXT(lbl, clock, reset, pre, post, msg)
`endif

`endif

### rtl/ile_pkg.sv
// Shared types for the indexed list engine: command codes, status codes
// and sequencer states. No dependencies.
package ile_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_ACCESS,
    S_FIND,
    S_DONE
  } state_t;

endpackage

### rtl/indexed_list_engine.sv
// Indexed list engine: ordered word list in one RAM, walked by a small sequencer.
// Depends on ile_pkg and indexed_list_engine_defines.svh.
// Clear, spare codes and failing commands go straight to S_DONE; read and write do
// one RAM access; insert shifts up from the end, then puts; remove shifts down;
// find scans to a hit or the end. One transaction at a time; in_stall drops as
// out_valid rises. Reset empties the list; RAM contents are left as they are.
`include "indexed_list_engine_defines.svh"

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [4:0]  position,
  input  logic [31:0] word_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] word_out,
  output logic [3:0]  hit_position,
  output logic        hit,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  state_t               state, state_next;
  cmd_t                 cmd_q;
  logic [CW-1:0]        pos_q;
  logic [WORD_BITS-1:0] word_q;
  logic [CW-1:0]        cur;
  logic                 pend;
  logic                 grab;
  logic [AW-1:0]        pend_addr;
  logic [WORD_BITS-1:0] res_word;
  logic                 res_hit;
  logic [AW-1:0]        res_hpos;
  status_t              res_status;
  logic [CW-1:0]        fill;

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        rd_addr;

  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        fill_x;
  logic [AW-1:0]        pos_a;
  logic [AW-1:0]        cur_m1;
  logic [63:0]          win64;
  logic [63:0]          res_word64;
  logic [63:0]          fill64;
  logic [63:0]          hpos64;
  logic                 accept;
  logic                 match;
  logic                 out_free;

  assign pos_x      = XW'(position);
  assign fill_x     = XW'(fill);
  assign pos_a      = pos_x[AW-1:0];
  assign cur_m1     = cur[AW-1:0] - AW'(1);
  assign win64      = 64'(word_in);
  assign res_word64 = 64'(res_word);
  assign fill64     = 64'(fill);
  assign hpos64     = 64'(res_hpos);
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign match      = pend && (rdata == word_q);
  assign out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = pend_addr;
    mem_wdata  = rdata;
    rd_addr    = cur[AW-1:0];
    unique case (state)
      S_IDLE: begin
        rd_addr = pos_a;
        if (in_valid) begin
          unique case (cmd_t'(cmd))
            CMD_INSERT: begin
              if (pos_x > fill_x || fill == CW'(CAPACITY)) begin
                state_next = S_DONE;
              end else begin
                state_next = S_SHIFT_UP;
              end
            end
            CMD_REMOVE: begin
              state_next = (pos_x >= fill_x) ? S_DONE : S_SHIFT_DN;
            end
            CMD_READ, CMD_WRITE: begin
              state_next = (pos_x >= fill_x) ? S_DONE : S_ACCESS;
            end
            CMD_FIND: begin
              state_next = S_FIND;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        mem_we  = pend;
        rd_addr = cur_m1;
        if (!(cur > pos_q)) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_q[AW-1:0];
        mem_wdata  = word_q;
        state_next = S_DONE;
      end
      S_SHIFT_DN: begin
        mem_we = pend && !grab;
        if (cur >= fill) begin
          state_next = S_DONE;
        end
      end
      S_ACCESS: begin
        mem_we     = (cmd_q == CMD_WRITE);
        mem_waddr  = pos_q[AW-1:0];
        mem_wdata  = word_q;
        state_next = S_DONE;
      end
      S_FIND: begin
        if (match || cur >= fill) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      pend      <= 1'b0;
      grab      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= cmd_t'(cmd);
            pos_q      <= pos_x[CW-1:0];
            word_q     <= win64[WORD_BITS-1:0];
            res_word   <= '0;
            res_hit    <= 1'b0;
            res_hpos   <= '0;
            res_status <= STAT_OK;
            pend       <= 1'b0;
            grab       <= 1'b0;
            unique case (cmd_t'(cmd))
              CMD_CLEAR: begin
                fill <= '0;
              end
              CMD_INSERT: begin
                if (pos_x > fill_x) begin
                  res_status <= STAT_RANGE;
                end else if (fill == CW'(CAPACITY)) begin
                  res_status <= STAT_FULL;
                end else begin
                  cur <= fill;
                end
              end
              CMD_REMOVE: begin
                if (pos_x >= fill_x) begin
                  res_status <= STAT_RANGE;
                end else begin
                  cur       <= pos_x[CW-1:0] + CW'(1);
                  pend      <= 1'b1;
                  grab      <= 1'b1;
                  pend_addr <= pos_a;
                end
              end
              CMD_READ, CMD_WRITE: begin
                if (pos_x >= fill_x) begin
                  res_status <= STAT_RANGE;
                end
              end
              CMD_FIND: begin
                cur <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT_UP: begin
          if (cur > pos_q) begin
            pend      <= 1'b1;
            pend_addr <= cur[AW-1:0];
            cur       <= cur - CW'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        S_PUT: begin
          fill <= fill + CW'(1);
        end
        S_SHIFT_DN: begin
          grab <= 1'b0;
          if (grab) begin
            res_word <= rdata;
          end
          if (cur < fill) begin
            pend      <= 1'b1;
            pend_addr <= cur_m1;
            cur       <= cur + CW'(1);
          end else begin
            pend <= 1'b0;
            fill <= fill - CW'(1);
          end
        end
        S_ACCESS: begin
          res_word <= rdata;
        end
        S_FIND: begin
          if (match) begin
            res_hit  <= 1'b1;
            res_hpos <= pend_addr;
          end
          if (cur < fill) begin
            pend      <= 1'b1;
            pend_addr <= cur[AW-1:0];
            cur       <= cur + CW'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        S_DONE: begin
          pend <= 1'b0;
          if (out_free) begin
            out_valid    <= 1'b1;
            word_out     <= res_word64[31:0];
            hit_position <= hpos64[3:0];
            hit          <= res_hit;
            status       <= res_status;
            entry_count  <= fill64[4:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ILE_ASSERT(a_fill_bound, clk, rst, fill <= CW'(CAPACITY), "fill count above capacity")
  `ILE_ASSERT_NEXT(a_put_grows, clk, rst, state == S_PUT, fill == $past(fill) + CW'(1), "insert did not grow list")
  `ILE_ASSERT(a_we_states, clk, rst, !mem_we || (state != S_IDLE && state != S_DONE && state != S_FIND), "RAM write outside a write state")
  `ILE_ASSERT(a_shift_addr, clk, rst, !(mem_we && state == S_SHIFT_UP) || CW'(mem_waddr) <= fill, "shift writes past the list end")
  `ILE_ASSERT(a_hit_find, clk, rst, !(state == S_DONE && res_hit) || cmd_q == CMD_FIND, "hit set outside find")

endmodule

### tb/indexed_list_engine_tb.sv
// Self-checking testbench for indexed_list_engine: random and directed list commands
// are checked against a behavioral list kept by a small scoreboard class.
// Depends on ile_pkg and the indexed_list_engine RTL.
module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int ITEM_TARGET = 950;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 240;
  localparam int TAIL_CYCLES = 40;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  hit_pos;
    logic        hit;
    status_t     status;
    logic [4:0]  count;
  } list_result_t;

  class list_scoreboard;
    logic [31:0]  slots [LIST_DEPTH];
    int unsigned  fill;
    list_result_t expected_q [$];
    int           mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void note_input(logic [2:0] op, logic [4:0] pos, logic [31:0] word);
      list_result_t r;
      int           i;
      bit           found;
      r = '0;
      r.status = STAT_OK;
      found = 1'b0;
      case (op)
        CMD_CLEAR: fill = 0;
        CMD_INSERT: begin
          if (pos > fill) begin
            r.status = STAT_RANGE;
          end else if (fill >= LIST_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = word;
            fill++;
          end
        end
        CMD_REMOVE: begin
          if (pos >= fill) begin
            r.status = STAT_RANGE;
          end else begin
            r.word = slots[pos];
            for (i = pos + 1; i < fill; i++) slots[i-1] = slots[i];
            fill--;
          end
        end
        CMD_READ: begin
          if (pos >= fill) r.status = STAT_RANGE;
          else r.word = slots[pos];
        end
        CMD_WRITE: begin
          if (pos >= fill) begin
            r.status = STAT_RANGE;
          end else begin
            r.word = slots[pos];
            slots[pos] = word;
          end
        end
        CMD_FIND: begin
          for (i = 0; i < fill; i++) begin
            if (!found && slots[i] == word) begin
              found = 1'b1;
              r.hit = 1'b1;
              r.hit_pos = i[3:0];
            end
          end
        end
        default: ;
      endcase
      r.count = fill[4:0];
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing outstanding, word_out=%h status=%0d",
                         got.word, got.status));
        return;
      end
      want = expected_q.pop_front();
      if (got.word !== want.word)
        report($sformatf("word_out %h, expected %h", got.word, want.word));
      if (got.hit_pos !== want.hit_pos)
        report($sformatf("hit_position %0d, expected %0d", got.hit_pos, want.hit_pos));
      if (got.hit !== want.hit)
        report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.count !== want.count)
        report($sformatf("entry_count %0d, expected %0d", got.count, want.count));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [4:0]  position;
  logic [31:0] word_in;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] word_out;
  logic [3:0]  hit_position;
  logic        hit;
  logic [1:0]  status;
  logic [4:0]  entry_count;

  list_scoreboard sb;
  bit sender_idle;
  bit receiver_idle;
  bit took_result;
  int hold_req;
  int stall_left;
  int items_sent;
  int quiet_cycles;

  indexed_list_engine #(
    .CAPACITY(LIST_DEPTH),
    .WORD_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .position(position),
    .word_in(word_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_out(word_out),
    .hit_position(hit_position),
    .hit(hit),
    .status(status),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    list_result_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.word = word_out;
        got.hit_pos = hit_position;
        got.hit = hit;
        got.status = status_t'(status);
        got.count = entry_count;
        sb.check_result(got);
        took_result = 1'b1;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("indexed_list_engine regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (took_result) begin
        took_result = 1'b0;
        stall_left = receiver_idle ? $urandom_range(0, 13) : 0;
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      out_stall = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_cmd(input logic [2:0] op, input logic [4:0] pos,
                          input logic [31:0] word);
    int gap;
    gap = sender_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = op;
    position = pos;
    word_in = word;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, pos, word);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel <= 4 && sb.fill > 0) return sb.slots[$urandom_range(0, sb.fill - 1)];
    if (sel == 5) return 32'($urandom_range(0, 3));
    return $urandom;
  endfunction

  function automatic logic [4:0] valid_pos(logic [2:0] op);
    if (op == CMD_INSERT) return 5'($urandom_range(0, sb.fill));
    if (sb.fill == 0) return 5'd0;
    return 5'($urandom_range(0, sb.fill - 1));
  endfunction

  task automatic run_fill();
    while (sb.fill < LIST_DEPTH) send_cmd(CMD_INSERT, valid_pos(CMD_INSERT), pick_word());
    send_cmd(CMD_FIND, 5'($urandom_range(0, 31)), sb.slots[LIST_DEPTH - 1]);
    send_cmd(CMD_INSERT, 5'(LIST_DEPTH), pick_word());
    send_cmd(CMD_INSERT, 5'($urandom_range(0, LIST_DEPTH)), pick_word());
    send_cmd(CMD_INSERT, 5'($urandom_range(LIST_DEPTH + 1, 31)), pick_word());
  endtask

  task automatic run_drain();
    while (sb.fill > 0) send_cmd(CMD_REMOVE, valid_pos(CMD_REMOVE), pick_word());
    send_cmd(CMD_REMOVE, 5'($urandom_range(0, 31)), pick_word());
  endtask

  task automatic run_mixed(int n);
    int         k;
    int         sel;
    logic [2:0] op;
    logic [4:0] pos;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) op = CMD_CLEAR;
      else if (sel < 30) op = CMD_INSERT;
      else if (sel < 48) op = CMD_REMOVE;
      else if (sel < 63) op = CMD_READ;
      else if (sel < 78) op = CMD_WRITE;
      else if (sel < 95) op = CMD_FIND;
      else op = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      pos = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : valid_pos(op);
      send_cmd(op, pos, pick_word());
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_CLEAR;
    position = 5'd0;
    word_in = 32'h0;
    out_stall = 1'b0;
    took_result = 1'b0;
    hold_req = 0;
    stall_left = 0;
    items_sent = 0;
    quiet_cycles = 0;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_cmd(CMD_CLEAR, 5'd0, 32'h0);
    send_cmd(CMD_READ, 5'd0, 32'h0);
    send_cmd(CMD_REMOVE, 5'd0, 32'h0);
    send_cmd(CMD_WRITE, 5'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_FIND, 5'd0, 32'h0);
    send_cmd(CMD_INSERT, 5'd1, 32'h1);
    send_cmd(CMD_INSERT, 5'd0, 32'h0);
    send_cmd(CMD_INSERT, 5'd1, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 5'd0, 32'hA5A5_A5A5);
    send_cmd(CMD_INSERT, 5'd31, 32'h1234_5678);
    send_cmd(CMD_FIND, 5'd31, 32'hFFFF_FFFF);
    send_cmd(CMD_FIND, 5'd0, 32'h1234_5678);
    send_cmd(CMD_READ, 5'd2, 32'h0);
    send_cmd(CMD_READ, 5'd3, 32'h0);
    send_cmd(CMD_WRITE, 5'd1, 32'h5A5A_5A5A);
    send_cmd(CMD_REMOVE, 5'd0, 32'h0);
    send_cmd(CMD_REMOVE, 5'd16, 32'h0);
    send_cmd(CMD_SPARE_6, 5'd31, 32'hFFFF_FFFF);
    send_cmd(CMD_SPARE_7, 5'd0, 32'h0);
    send_cmd(CMD_INSERT, 5'd1, 32'h5A5A_5A5A);
    send_cmd(CMD_FIND, 5'd16, 32'h5A5A_5A5A);
    send_cmd(CMD_CLEAR, 5'd31, 32'hFFFF_FFFF);
    send_cmd(CMD_READ, 5'd0, 32'h0);

    run_fill();
    wait_drained();
    hold_req = LONG_HOLD;
    sender_idle = 1'b0;
    run_mixed(8);
    sender_idle = 1'b1;
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: run_fill();
        1: run_drain();
        default: run_mixed($urandom_range(10, 40));
      endcase
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("indexed_list_engine regression: pass");
    end else begin
      $display("indexed_list_engine regression: fail");
    end
    $finish;
  end

endmodule
